// ===== rtl/bcps_pkg.sv =====
// ----------------------------------------------------------------------------
// bcps_pkg
// Shared widths, codes, reset values and types for the best-candidate sampler.
// ----------------------------------------------------------------------------
package bcps_pkg;

    // field widths
    localparam int X_W        = 16;
    localparam int R_W        = 12;
    localparam int SCORE_W    = 33;
    localparam int CNT_W      = 11;
    localparam int CPP_W      = 5;
    localparam int LIMIT_W    = 11;
    localparam int IMG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // default parameter values
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_FRAC_BITS  = 8;

    // score of an empty store
    localparam longint SCORE_MAX = 64'sd2147483648;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CPP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG   = 2'd2;

    // register reset values
    localparam logic [CPP_W-1:0]   CPP_RESET   = 5'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd50;
    localparam logic [IMG_W-1:0]   IMG_RESET   = 9'd256;

    // command codes
    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // one stored point
    typedef struct packed {
        logic [X_W-1:0] x;
        logic [X_W-1:0] y;
        logic [R_W-1:0] r;
    } t_point;

    // control from the sequencer into the score pipe
    typedef struct packed {
        logic start;
        logic vld;
    } t_scan_ctl;

    // status back from the score pipe
    typedef struct packed {
        logic busy;
    } t_scan_stat;

endpackage

// ===== rtl/bcps_score_pipe.sv =====
// ----------------------------------------------------------------------------
// bcps_score_pipe
// Three-stage distance pipe: toroidal axis distances, squares, running minimum
// of squared distance less squared radius sum over one scan of the store.
// ----------------------------------------------------------------------------
module bcps_score_pipe #(
    parameter int FRAC_BITS = bcps_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bcps_pkg::t_scan_ctl                 i_ctl,
    input  bcps_pkg::t_point                    i_pt,
    input  bcps_pkg::t_point                    i_cand,
    input  logic [bcps_pkg::IMG_W-1:0]          i_img,
    output bcps_pkg::t_scan_stat                o_stat,
    output logic signed [bcps_pkg::SCORE_W-1:0] o_score
);
    import bcps_pkg::*;

    localparam int DW    = (FRAC_BITS + IMG_W > X_W) ? FRAC_BITS + IMG_W : X_W;
    localparam int RS_W  = R_W + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int ACC_W = 2 * DW + 2;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SCORE_MAX);

    // magnitude of the wrapped per-axis distance
    function automatic logic [DW-1:0] wrap_mag(input logic [X_W-1:0] a,
                                               input logic [X_W-1:0] b,
                                               input logic [DW-1:0]  half,
                                               input logic [DW-1:0]  full);
        logic [X_W-1:0] d;
        logic [DW-1:0]  dw;
        d  = (a > b) ? a - b : b - a;
        dw = DW'(d);
        if (dw > half) begin
            wrap_mag = (dw > full) ? dw - full : full - dw;
        end else begin
            wrap_mag = dw;
        end
    endfunction

    logic [DW-1:0] half_len;
    logic [DW-1:0] full_len;

    logic                    r_v1;
    logic [DW-1:0]           r_mx;
    logic [DW-1:0]           r_my;
    logic [RS_W-1:0]         r_rs;
    logic                    r_v2;
    logic [SQ_W-1:0]         r_sx;
    logic [SQ_W-1:0]         r_sy;
    logic [2*RS_W-1:0]       r_srs;
    logic signed [ACC_W-1:0] r_min;
    logic signed [ACC_W-1:0] n_sum;

    // wrap thresholds in fixed point
    assign half_len = DW'(i_img >> 1) << FRAC_BITS;
    assign full_len = DW'(i_img) << FRAC_BITS;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.vld;
            r_v2 <= r_v1;
        end
    end

    // stage 1: axis distances and radius sum
    always_ff @(posedge i_clk) begin
        r_mx <= wrap_mag(i_cand.x, i_pt.x, half_len, full_len);
        r_my <= wrap_mag(i_cand.y, i_pt.y, half_len, full_len);
        r_rs <= RS_W'(i_cand.r) + RS_W'(i_pt.r);
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        r_sx  <= r_mx * r_mx;
        r_sy  <= r_my * r_my;
        r_srs <= r_rs * r_rs;
    end

    // stage 3: running minimum
    assign n_sum = $signed(ACC_W'(r_sx) + ACC_W'(r_sy) - ACC_W'(r_srs));

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_min <= ACC_MAX;
        end else if (r_v2 && (n_sum < r_min)) begin
            r_min <= n_sum;
        end
    end

    assign o_stat.busy = r_v1 | r_v2;
    assign o_score     = $signed(r_min[SCORE_W-1:0]);

endmodule

// ===== rtl/best_candidate_point_sampler.sv =====
// ----------------------------------------------------------------------------
// best_candidate_point_sampler
// Best-candidate blue-noise point sampler on a square torus with a point store.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. An evaluate beat reads every stored point
// from the point memory, one per cycle through its single read port, and feeds
// them through the score pipe; with an empty store no read is issued. A clear
// beat goes straight to the final state. A new input beat is taken while the
// previous result beat still waits on the output. The score is the minimum,
// over stored points, of the toroidal squared distance less the squared radius
// sum, in Q16.16, and 2^31 for an empty store. When a round closes the best
// candidate is written to the store and reported with committed set; a full
// store drops the point and sets store_full. Point memory contents are
// undefined until written.
module best_candidate_point_sampler #(
    parameter int MAX_POINTS = bcps_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = bcps_pkg::DEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [bcps_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [bcps_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_cmd,
    input  logic [bcps_pkg::X_W-1:0]               i_cand_x,
    input  logic [bcps_pkg::X_W-1:0]               i_cand_y,
    input  logic [bcps_pkg::R_W-1:0]               i_cand_radius,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bcps_pkg::SCORE_W-1:0]    o_score,
    output logic                                   o_committed,
    output logic [bcps_pkg::X_W-1:0]               o_best_x,
    output logic [bcps_pkg::X_W-1:0]               o_best_y,
    output logic [bcps_pkg::R_W-1:0]               o_best_radius,
    output logic [bcps_pkg::CNT_W-1:0]             o_point_count,
    output logic                                   o_store_full
);
    import bcps_pkg::*;

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int TW0   = CW + CPP_W + 1;
    localparam int TW    = (TW0 > LIMIT_W) ? TW0 : LIMIT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    // configuration registers
    logic [CPP_W-1:0]   r_cpp;
    logic [LIMIT_W-1:0] r_limit;
    logic [IMG_W-1:0]   r_img;

    // sequencer and round state
    t_state                    r_state;
    logic                      r_cmd;
    t_point                    r_cand;
    logic [CW-1:0]             r_stored;
    logic [CNT_W-1:0]          r_seen;
    logic                      r_have_best;
    logic signed [SCORE_W-1:0] r_best_score;
    t_point                    r_best_pt;
    logic [CW-1:0]             r_rd_cnt;
    logic                      r_rd_vld;
    t_point                    r_rd_data;
    t_point                    r_mem [MAX_POINTS];

    // output register
    logic                      r_out_valid;
    logic signed [SCORE_W-1:0] r_out_score;
    logic                      r_out_committed;
    t_point                    r_out_best;
    logic [CNT_W-1:0]          r_out_count;
    logic                      r_out_full;

    // combinational
    logic                      in_acc;
    logic                      rd_issue;
    logic                      scan_done;
    logic                      out_free;
    logic                      mem_wr;
    t_scan_ctl                 scan_ctl;
    t_scan_stat                scan_stat;
    t_point                    cand_in;
    logic signed [SCORE_W-1:0] pipe_score;
    logic                      take;
    t_point                    n_best_pt;
    logic signed [SCORE_W-1:0] n_best_score;
    logic [CNT_W-1:0]          n_seen;
    logic [TW-1:0]             target_raw;
    logic [TW-1:0]             target;
    logic                      close;
    logic                      is_full;
    logic [CW-1:0]             n_stored;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpp   <= CPP_RESET;
            r_limit <= LIMIT_RESET;
            r_img   <= IMG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CPP:   r_cpp   <= i_cfg_data[CPP_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_IMG:   r_img   <= i_cfg_data[IMG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake terms
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign rd_issue   = (r_state == S_SCAN) && (r_rd_cnt != r_stored);
    assign scan_done  = (r_rd_cnt == r_stored) && !r_rd_vld && !scan_stat.busy;

    assign cand_in.x = i_cand_x;
    assign cand_in.y = i_cand_y;
    assign cand_in.r = i_cand_radius;

    // score pipe
    assign scan_ctl.start = in_acc;
    assign scan_ctl.vld   = r_rd_vld;

    bcps_score_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_score_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_pt    (r_rd_data),
        .i_cand  (r_cand),
        .i_img   (r_img),
        .o_stat  (scan_stat),
        .o_score (pipe_score)
    );

    // round bookkeeping at the end of an evaluate beat
    assign take         = !r_have_best || (pipe_score > r_best_score);
    assign n_best_pt    = take ? r_cand : r_best_pt;
    assign n_best_score = take ? pipe_score : r_best_score;
    assign n_seen       = r_seen + CNT_W'(1);
    assign target_raw   = TW'(r_stored) * TW'(r_cpp) + TW'(1);
    assign target       = (target_raw > TW'(r_limit)) ? TW'(r_limit) : target_raw;
    assign close        = TW'(n_seen) >= target;
    assign is_full      = (r_stored == CW'(MAX_POINTS));
    assign n_stored     = r_stored + CW'(1);
    assign mem_wr       = (r_state == S_FIN) && out_free && (r_cmd == CMD_EVAL)
                          && close && !is_full;

    // point memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_stored[AW-1:0]] <= n_best_pt;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_cnt[AW-1:0]];
        end
    end

    // sequencer, round state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_stored     <= '0;
            r_seen       <= '0;
            r_have_best  <= 1'b0;
            r_best_score <= '0;
            r_best_pt    <= '0;
            r_rd_cnt     <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_vld <= rd_issue;
            // result beat: load in the final state, drop once taken
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd    <= i_cmd;
                        r_cand   <= cand_in;
                        r_rd_cnt <= '0;
                        r_state  <= (i_cmd == CMD_CLEAR) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_issue) begin
                        r_rd_cnt <= r_rd_cnt + CW'(1);
                    end
                    if (scan_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        if (r_cmd == CMD_CLEAR) begin
                            // empty the store and the round
                            r_stored        <= '0;
                            r_seen          <= '0;
                            r_have_best     <= 1'b0;
                            r_best_score    <= '0;
                            r_best_pt       <= '0;
                            r_out_score     <= '0;
                            r_out_committed <= 1'b0;
                            r_out_best      <= '0;
                            r_out_count     <= '0;
                            r_out_full      <= 1'b0;
                        end else if (close) begin
                            // commit the round winner
                            r_seen          <= '0;
                            r_have_best     <= 1'b0;
                            r_best_score    <= '0;
                            r_best_pt       <= '0;
                            r_out_score     <= pipe_score;
                            r_out_committed <= 1'b1;
                            r_out_best      <= n_best_pt;
                            r_out_full      <= is_full;
                            if (!is_full) begin
                                r_stored    <= n_stored;
                                r_out_count <= CNT_W'(n_stored);
                            end else begin
                                r_out_count <= CNT_W'(r_stored);
                            end
                        end else begin
                            // keep the best so far
                            r_seen          <= n_seen;
                            r_have_best     <= 1'b1;
                            r_best_score    <= n_best_score;
                            r_best_pt       <= n_best_pt;
                            r_out_score     <= pipe_score;
                            r_out_committed <= 1'b0;
                            r_out_best      <= '0;
                            r_out_count     <= CNT_W'(r_stored);
                            r_out_full      <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_score       = r_out_score;
    assign o_committed   = r_out_committed;
    assign o_best_x      = r_out_best.x;
    assign o_best_y      = r_out_best.y;
    assign o_best_radius = r_out_best.r;
    assign o_point_count = r_out_count;
    assign o_store_full  = r_out_full;

endmodule
